[rtl/ptga_pkg.sv]
// Shared types, codes and sizes for the per-thread group accumulator.
package ptga_pkg;

    localparam int MAX_GROUPS = 16;
    localparam int SLOT_W     = $clog2(MAX_GROUPS);
    localparam int CNT_W      = $clog2(MAX_GROUPS + 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BADKEY = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_RANGE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_GATHER
    } state_t;

    // One table entry, held by one cell.
    typedef struct packed {
        logic [30:0] key;
        logic [31:0] leader;
        logic [63:0] runtime;
        logic [63:0] deadline;
        logic [63:0] period;
        logic [11:0] cpu;
        logic [31:0] members;
    } entry_t;

    // Fields of an add request that every cell sees.
    typedef struct packed {
        logic [30:0] key;
        logic [31:0] member_id;
        logic [63:0] runtime;
        logic [63:0] deadline;
        logic [63:0] period;
        logic [11:0] cpu;
    } cell_req_t;

    // Update control broadcast from the sequencer to the cells.
    typedef struct packed {
        logic              add_en;
        logic              append_en;
        logic [SLOT_W-1:0] append_slot;
    } cell_ctl_t;

    // Lookup result handed from cell to cell.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } look_t;

endpackage

[rtl/ptga_cell.sv]
// One table cell: holds an entry, compares the key and applies an add.
module ptga_cell
    import ptga_pkg::*;
(
    input  logic              clk,
    input  logic [SLOT_W-1:0] cell_index,
    input  logic              live,
    input  cell_ctl_t         ctl,
    input  cell_req_t         req,
    input  look_t             look_in,
    output look_t             look_out,
    input  logic [SLOT_W-1:0] rd_slot,
    input  entry_t            rd_in,
    output entry_t            rd_out
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t base;
    logic   match;
    logic   target;
    logic   apply;

    assign match  = live && (entry_reg.key == req.key);
    assign target = ctl.append_en && (ctl.append_slot == cell_index);
    assign apply  = ctl.add_en && (match || target);

    assign look_out.hit  = look_in.hit | match;
    assign look_out.slot = match ? cell_index : look_in.slot;

    assign rd_out = (rd_slot == cell_index) ? entry_reg : rd_in;

    always_comb
    begin
        // a fresh entry starts with leader all ones and everything else zero
        if (target)
        begin
            base          = '0;
            base.leader   = '1;
        end
        else
        begin
            base = entry_reg;
        end
        entry_next          = base;
        entry_next.key      = req.key;
        entry_next.runtime  = base.runtime + req.runtime;
        entry_next.deadline = base.deadline + req.deadline;
        entry_next.period   = req.period;
        entry_next.cpu      = req.cpu;
        if ((base.members == 32'd0) || (req.member_id < base.leader))
        begin
            entry_next.leader = req.member_id;
        end
        entry_next.members  = base.members + 32'd1;
    end

    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

[rtl/per_thread_group_accumulator_unit.sv]
// Per-thread group accumulator: a row of table cells with a small sequencer.
// A request passes ST_LOOK, which runs the lookup and update pass along the cell
// row, then ST_GATHER, which runs the readout pass and registers the result; it stays
// in ST_GATHER while out_stall holds. A new request is taken in ST_IDLE or as the result is registered.
// Reset clears the entry count and handshake state; entry contents are undefined
// until written and there is no clearing pass.
module per_thread_group_accumulator_unit
    import ptga_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [31:0]         member_id,
    input  logic signed [31:0]  thread_key,
    input  logic [63:0]         runtime_ns,
    input  logic [63:0]         deadline_ns,
    input  logic [63:0]         period_ns,
    input  logic [11:0]         cpu_index,
    input  logic [3:0]          read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [3:0]          slot,
    output logic [30:0]         group_key,
    output logic [31:0]         leader,
    output logic [63:0]         runtime_sum,
    output logic [63:0]         deadline_sum,
    output logic [63:0]         group_period,
    output logic [11:0]         group_cpu,
    output logic [31:0]         member_count,
    output logic [4:0]          used_entries
);

    state_t state_reg;
    state_t state_next;

    logic [1:0]        cmd_reg;
    logic [31:0]       key_reg;
    logic [3:0]        ridx_reg;
    cell_req_t         req_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    status_t           res_status_reg;
    status_t           res_status_next;
    logic              res_entry_reg;
    logic              res_entry_next;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [SLOT_W-1:0] res_slot_next;

    logic              out_valid_reg;
    status_t           status_reg;
    logic [3:0]        slot_reg;
    entry_t            entry_out_reg;
    logic [4:0]        used_reg;

    logic              accept;
    logic              out_free;
    logic              key_ok;
    logic              full;
    logic              any_hit;
    logic              add_go;
    logic              append_go;
    cell_ctl_t         ctl;

    look_t             look_chain [MAX_GROUPS+1];
    entry_t            rd_chain   [MAX_GROUPS+1];
    logic [MAX_GROUPS-1:0] live;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_GATHER) && out_free));
    assign accept   = in_valid && !in_stall;

    assign key_ok    = (key_reg != 32'd0) && !key_reg[31];
    assign full      = (count_reg == CNT_W'(MAX_GROUPS));
    assign any_hit   = look_chain[MAX_GROUPS].hit;
    assign add_go    = (state_reg == ST_LOOK) && (cmd_reg == CMD_ADD) && key_ok;
    assign append_go = add_go && !any_hit && !full;

    assign ctl.add_en      = add_go;
    assign ctl.append_en   = append_go;
    assign ctl.append_slot = count_reg[SLOT_W-1:0];

    assign look_chain[0] = '0;
    assign rd_chain[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_GROUPS; gi++)
        begin : g_cell
            assign live[gi] = (CNT_W'(gi) < count_reg);

            ptga_cell u_cell (
                .clk        (clk),
                .cell_index (SLOT_W'(gi)),
                .live       (live[gi]),
                .ctl        (ctl),
                .req        (req_reg),
                .look_in    (look_chain[gi]),
                .look_out   (look_chain[gi+1]),
                .rd_slot    (res_slot_reg),
                .rd_in      (rd_chain[gi]),
                .rd_out     (rd_chain[gi+1])
            );
        end
    endgenerate

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_GATHER;
            end
            ST_GATHER:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // decide the outcome of the request during the lookup pass
    always_comb
    begin
        count_next      = count_reg;
        res_status_next = STATUS_OK;
        res_entry_next  = 1'b0;
        res_slot_next   = '0;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (!key_ok)
                begin
                    res_status_next = STATUS_BADKEY;
                end
                else if (any_hit)
                begin
                    res_entry_next = 1'b1;
                    res_slot_next  = look_chain[MAX_GROUPS].slot;
                end
                else if (!full)
                begin
                    res_entry_next = 1'b1;
                    res_slot_next  = count_reg[SLOT_W-1:0];
                    count_next     = count_reg + CNT_W'(1);
                end
                else
                begin
                    res_status_next = STATUS_FULL;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_READ:
            begin
                if (CNT_W'(ridx_reg) < count_reg)
                begin
                    res_entry_next = 1'b1;
                    res_slot_next  = SLOT_W'(ridx_reg);
                end
                else
                begin
                    res_status_next = STATUS_RANGE;
                end
            end
            default:
            begin
                res_status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_LOOK)
            begin
                count_reg <= count_next;
            end
            if ((state_reg == ST_GATHER) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request, outcome and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg           <= command;
            key_reg           <= thread_key;
            ridx_reg          <= read_index;
            req_reg.key       <= thread_key[30:0];
            req_reg.member_id <= member_id;
            req_reg.runtime   <= runtime_ns;
            req_reg.deadline  <= deadline_ns;
            req_reg.period    <= period_ns;
            req_reg.cpu       <= cpu_index;
        end
        if (state_reg == ST_LOOK)
        begin
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
            res_slot_reg   <= res_slot_next;
        end
        if ((state_reg == ST_GATHER) && out_free)
        begin
            status_reg <= res_status_reg;
            used_reg   <= 5'(count_reg);
            if (res_entry_reg)
            begin
                slot_reg      <= 4'(res_slot_reg);
                entry_out_reg <= rd_chain[MAX_GROUPS];
            end
            else
            begin
                slot_reg      <= '0;
                entry_out_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign group_key    = entry_out_reg.key;
    assign leader       = entry_out_reg.leader;
    assign runtime_sum  = entry_out_reg.runtime;
    assign deadline_sum = entry_out_reg.deadline;
    assign group_period = entry_out_reg.period;
    assign group_cpu    = entry_out_reg.cpu;
    assign member_count = entry_out_reg.members;
    assign used_entries = used_reg;

endmodule
